// ===== sv/cp2p_pkg.sv =====
package cp2p_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int ITERATIONS = 16;
	localparam int TABLE_LEN = 24;
	localparam int FRAC_BITS = 46 - DATA_WIDTH;
	localparam int VW = 48;
	localparam int ZW = 34;
	localparam int ITER_IDX_W = $clog2(TABLE_LEN);
	localparam int ANG_SH = 32 - DATA_WIDTH;
	localparam int MAG_SH = 17 + FRAC_BITS;
	localparam int Q_W = VW - 1 - 15;
	localparam int PROD_W = 65;
	localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;
	localparam logic signed [ZW-1:0] ANGLE_HALF_PI = ZW'(64'sd1 <<< 30);
	localparam logic signed [ZW-1:0] ANG_RND =
		(ANG_SH > 0) ? ZW'(64'sd1 <<< (ANG_SH - 1)) : '0;
	localparam logic [PROD_W-1:0] MAG_RND = PROD_W'(65'd1 << (MAG_SH - 1));
	localparam logic [PROD_W-1:0] WMASK = PROD_W'((65'd1 << DATA_WIDTH) - 65'd1);

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 zero;
	} cp2p_vec_t;

	function automatic logic signed [ZW-1:0] atan_step(input logic [ITER_IDX_W-1:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = 34'sd536870912;
			5'd1:    v = 34'sd316933406;
			5'd2:    v = 34'sd167458907;
			5'd3:    v = 34'sd85004756;
			5'd4:    v = 34'sd42667331;
			5'd5:    v = 34'sd21354465;
			5'd6:    v = 34'sd10680350;
			5'd7:    v = 34'sd5340245;
			5'd8:    v = 34'sd2670163;
			5'd9:    v = 34'sd1335087;
			5'd10:   v = 34'sd667544;
			5'd11:   v = 34'sd333772;
			5'd12:   v = 34'sd166886;
			5'd13:   v = 34'sd83443;
			5'd14:   v = 34'sd41722;
			5'd15:   v = 34'sd20861;
			5'd16:   v = 34'sd10430;
			5'd17:   v = 34'sd5215;
			5'd18:   v = 34'sd2608;
			5'd19:   v = 34'sd1304;
			5'd20:   v = 34'sd652;
			5'd21:   v = 34'sd326;
			5'd22:   v = 34'sd163;
			5'd23:   v = 34'sd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/cp2p_prerot.sv =====
module cp2p_prerot
	import cp2p_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [DATA_WIDTH-1:0] x_in,
	input  logic signed [DATA_WIDTH-1:0] y_in,
	output logic                      out_valid,
	input  logic                      out_ready,
	output cp2p_vec_t                 out_vec
);

	logic      valid_s1;
	cp2p_vec_t vec_s1;
	cp2p_vec_t vec_d;
	logic signed [VW-1:0] xf;
	logic signed [VW-1:0] yf;

	assign in_ready = ~valid_s1 | out_ready;

	always_comb begin
		xf = VW'(x_in) <<< FRAC_BITS;
		yf = VW'(y_in) <<< FRAC_BITS;
		vec_d.zero = (x_in == '0) && (y_in == '0);
		vec_d.x = xf;
		vec_d.y = yf;
		vec_d.z = '0;
		if (xf < 0) begin
			if (yf >= 0) begin
				vec_d.x = yf;
				vec_d.y = -xf;
				vec_d.z = ANGLE_HALF_PI;
			end else begin
				vec_d.x = -yf;
				vec_d.y = xf;
				vec_d.z = -ANGLE_HALF_PI;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= vec_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

// ===== sv/cp2p_cell.sv =====
module cp2p_cell
	import cp2p_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ITER_IDX_W-1:0] iter,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cp2p_vec_t             in_vec,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cp2p_vec_t             out_vec
);

	logic      valid_s1;
	cp2p_vec_t vec_s1;
	cp2p_vec_t vec_d;
	logic signed [VW-1:0] dx;
	logic signed [VW-1:0] dy;
	logic signed [ZW-1:0] step;

	assign in_ready = ~valid_s1 | out_ready;

	always_comb begin
		dx   = in_vec.y >>> iter;
		dy   = in_vec.x >>> iter;
		step = atan_step(iter);
		vec_d.zero = in_vec.zero;
		if (in_vec.y < 0) begin
			vec_d.x = in_vec.x - dx;
			vec_d.y = in_vec.y + dy;
			vec_d.z = in_vec.z - step;
		end else begin
			vec_d.x = in_vec.x + dx;
			vec_d.y = in_vec.y - dy;
			vec_d.z = in_vec.z + step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= vec_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

// ===== sv/cp2p_gain.sv =====
module cp2p_gain
	import cp2p_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cp2p_vec_t             in_vec,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] magnitude,
	output logic [DATA_WIDTH-1:0] angle
);

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  ready_s2;
	logic [63:0]           p_hi_s1;
	logic [31:0]           p_lo_s1;
	logic [DATA_WIDTH-1:0] ang_s1;
	logic                  zero_s1;
	logic [DATA_WIDTH-1:0] mag_s2;
	logic [DATA_WIDTH-1:0] ang_s2;

	logic [VW-2:0]         m;
	logic [Q_W-1:0]        q;
	logic [14:0]           r;
	logic [46:0]           lo_full;
	logic signed [ZW-1:0]  zr;
	logic [PROD_W-1:0]     prod;
	logic [PROD_W-1:0]     mag_full;
	logic [DATA_WIDTH-1:0] mag_d;

	assign ready_s2 = ~valid_s2 | out_ready;
	assign in_ready = ~valid_s1 | ready_s2;

	always_comb begin
		m       = in_vec.x[VW-1] ? '0 : in_vec.x[VW-2:0];
		q       = m[VW-2:15];
		r       = m[14:0];
		lo_full = 47'(r) * 47'(INV_GAIN_Q32);
		zr      = in_vec.z + ANG_RND;
	end

	always_comb begin
		prod     = PROD_W'(p_hi_s1) + PROD_W'(p_lo_s1) + MAG_RND;
		mag_full = prod >> MAG_SH;
		mag_d    = (mag_full > WMASK) ? '1 : mag_full[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			p_hi_s1 <= 64'(q) * 64'(INV_GAIN_Q32);
			p_lo_s1 <= lo_full[46:15];
			ang_s1  <= zr[ANG_SH +: DATA_WIDTH];
			zero_s1 <= in_vec.zero;
		end
		if (ready_s2 && valid_s1) begin
			mag_s2 <= zero_s1 ? '0 : mag_d;
			ang_s2 <= zero_s1 ? '0 : ang_s1;
		end
	end

	assign out_valid = valid_s2;
	assign magnitude = mag_s2;
	assign angle     = ang_s2;

endmodule

// ===== sv/cartesian_to_polar_core.sv =====
// Each input passes the pre-rotation stage, the CORDIC cells and the gain stage to m_axis.
// Throughput: one transfer per cycle; each stage holds one item and stalls
// only when it is full and the stage after it cannot take its item.
// The chain holds ITERATIONS CORDIC cells, one rotation per cell.
// Reset: arst_n low clears all stage valid flags at once; data registers are not reset.
module cartesian_to_polar_core
	import cp2p_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [2*DATA_WIDTH-1:0] s_axis_tdata,  // x_in in the low half, y_in in the high half
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [2*DATA_WIDTH-1:0] m_axis_tdata   // magnitude in the low half, angle in the high half
);

	logic      valid_c [ITERATIONS+1];
	logic      ready_c [ITERATIONS+1];
	cp2p_vec_t vec_c   [ITERATIONS+1];
	logic [DATA_WIDTH-1:0] magnitude;
	logic [DATA_WIDTH-1:0] angle;

	cp2p_prerot u_prerot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.x_in      (s_axis_tdata[DATA_WIDTH-1:0]),
		.y_in      (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
		.out_valid (valid_c[0]),
		.out_ready (ready_c[0]),
		.out_vec   (vec_c[0])
	);

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		cp2p_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.iter      (ITER_IDX_W'(i)),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_vec    (vec_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_vec   (vec_c[i+1])
		);
	end

	cp2p_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c[ITERATIONS]),
		.in_ready  (ready_c[ITERATIONS]),
		.in_vec    (vec_c[ITERATIONS]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.magnitude (magnitude),
		.angle     (angle)
	);

	assign m_axis_tdata = {angle, magnitude};

endmodule

// ===== sv/cp2p_checker.sv =====
module cp2p_checker
	import cp2p_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [2*DATA_WIDTH-1:0] s_axis_tdata,
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [2*DATA_WIDTH-1:0] m_axis_tdata
);

	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output side is ready");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[DATA_WIDTH-1:0] <= 16'd46342))
		else $error("magnitude beyond largest vector length");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result dropped or changed");

endmodule

bind cartesian_to_polar_core cp2p_checker u_cp2p_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/cartesian_to_polar_checker.sv =====
`timescale 1ns / 100ps

module cartesian_to_polar_checker
	import cp2p_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [2*DATA_WIDTH-1:0] s_axis_tdata,   // x_in in the low half, y_in in the high half
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [2*DATA_WIDTH-1:0] m_axis_tdata,   // magnitude in the low half, angle in the high half
	output int                      fail_count,
	output int                      in_flight
);

	localparam int FRAC = 46 - DATA_WIDTH;
	localparam int MAG_SHIFT = 17 + FRAC;
	localparam int ANGLE_SHIFT = 32 - DATA_WIDTH;
	localparam int ARCTAN_LEN = 24;
	localparam longint unsigned RECIP_GAIN = 64'd2608131496;
	localparam longint unsigned MAG_MAX = (64'd1 << DATA_WIDTH) - 64'd1;
	localparam longint QUARTER_TURN = 64'sd1 <<< 30;
	localparam longint ARCTAN_RAD [ARCTAN_LEN] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10680350, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] angle;
		logic [DATA_WIDTH-1:0]        magnitude;
	} polar_t;

	polar_t polar_q [$];
	int     n_fail = 0;

	function automatic polar_t to_polar(input logic signed [DATA_WIDTH-1:0] xi,
	                                    input logic signed [DATA_WIDTH-1:0] yi);
		longint          x;
		longint          y;
		longint          z;
		longint          t;
		longint          dx;
		longint          dy;
		longint unsigned m;
		longint unsigned q;
		longint unsigned r;
		longint unsigned prod;
		longint unsigned mag;
		polar_t          res;
		res = '0;
		if (xi == 0 && yi == 0)
			return res;
		x = longint'(xi) <<< FRAC;
		y = longint'(yi) <<< FRAC;
		z = 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = QUARTER_TURN;
			end else begin
				x = -y;
				y = t;
				z = -QUARTER_TURN;
			end
		end
		for (int i = 0; i < ITERATIONS && i < ARCTAN_LEN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y < 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN_RAD[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN_RAD[i];
			end
		end
		m = (x < 0) ? 64'd0 : longint'(x);
		q = m >> 15;
		r = m & 64'h7FFF;
		prod = q * RECIP_GAIN + ((r * RECIP_GAIN) >> 15);
		mag = (prod + (64'd1 << (MAG_SHIFT - 1))) >> MAG_SHIFT;
		if (mag > MAG_MAX)
			mag = MAG_MAX;
		if (ANGLE_SHIFT > 0)
			z = (z + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
		res.magnitude = mag[DATA_WIDTH-1:0];
		res.angle = z[DATA_WIDTH-1:0];
		return res;
	endfunction

	always @(posedge clk) begin
		polar_t want;
		polar_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				polar_q.push_back(to_polar(s_axis_tdata[DATA_WIDTH-1:0],
				                           s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (polar_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected result: mag %0d angle %0d",
						         got.magnitude, got.angle);
				end else begin
					want = polar_q.pop_front();
					if (got.magnitude !== want.magnitude || got.angle !== want.angle) begin
						n_fail++;
						if (n_fail <= 10)
							$display("mismatch: expected mag %0d angle %0d, got mag %0d angle %0d",
							         want.magnitude, want.angle, got.magnitude, got.angle);
					end
				end
			end
			fail_count <= n_fail;
			in_flight <= polar_q.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import cp2p_pkg::*;

	localparam int PHASE_ITEMS = 320;
	localparam int DIRECTED_N = 24;
	localparam int DIR_X [DIRECTED_N] = '{
		0, 1, -1, 0, 0, 32767, -32768, 0, 0, 32767, -32768, 32767,
		-32768, -1, 1, 1, -5, 3, -32768, -32768, 100, -32767, 21845, -2
	};
	localparam int DIR_Y [DIRECTED_N] = '{
		0, 0, 0, 1, -1, 0, 0, 32767, -32768, 32767, -32768, -32768,
		32767, -1, -1, 1, 0, 4, -1, 1, -1, 0, -21846, 32767
	};

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [2*DATA_WIDTH-1:0] s_axis_tdata = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [2*DATA_WIDTH-1:0] m_axis_tdata;
	int                      gap_pct = 0;
	int                      stall_pct = 0;
	int                      fail_count;
	int                      in_flight;

	cartesian_to_polar_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	cartesian_to_polar_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.in_flight     (in_flight)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		#500000;
		$display("FAIL");
		$finish;
	end

	task automatic send_vector(input logic signed [DATA_WIDTH-1:0] x,
	                           input logic signed [DATA_WIDTH-1:0] y);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (in_flight != 0);
	endtask

	function automatic logic [DATA_WIDTH-1:0] pick_component(input int kind);
		logic [DATA_WIDTH-1:0] v;
		case (kind)
			0:       v = DATA_WIDTH'($urandom_range(32) - 16);
			1:       v = '0;
			2: begin
				case ($urandom_range(5))
					0:       v = {1'b1, {(DATA_WIDTH-1){1'b0}}};
					1:       v = {1'b1, {(DATA_WIDTH-2){1'b0}}, 1'b1};
					2:       v = '1;
					3:       v = DATA_WIDTH'(1);
					4:       v = {1'b0, {(DATA_WIDTH-2){1'b1}}, 1'b0};
					default: v = {1'b0, {(DATA_WIDTH-1){1'b1}}};
				endcase
			end
			default: v = DATA_WIDTH'($urandom);
		endcase
		return v;
	endfunction

	task automatic send_random();
		int sel;
		sel = $urandom_range(19);
		if (sel < 13)
			send_vector(pick_component(3), pick_component(3));
		else if (sel < 15)
			send_vector(pick_component(0), pick_component(0));
		else if (sel < 16)
			send_vector(pick_component(1), pick_component(3));
		else if (sel < 17)
			send_vector(pick_component(3), pick_component(1));
		else if (sel < 19)
			send_vector(pick_component(2), pick_component(2));
		else
			send_vector(pick_component(2), pick_component(3));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIR_X[i])
			send_vector(DATA_WIDTH'(DIR_X[i]), DATA_WIDTH'(DIR_Y[i]));
		drain_results();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 72;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 72;
				end
				default: begin
					gap_pct = 14;
					stall_pct = 14;
				end
			endcase
			repeat (PHASE_ITEMS)
				send_random();
			drain_results();
		end
		repeat (40) @(posedge clk);
		if (fail_count == 0 && in_flight == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cp2p_pkg.sv
sv/cp2p_prerot.sv
sv/cp2p_cell.sv
sv/cp2p_gain.sv
sv/cartesian_to_polar_core.sv
sv/cp2p_checker.sv
verif/cartesian_to_polar_checker.sv
verif/tb_top.sv
